@@ rtl/mflg_pkg.sv @@
// Shared sizes, codes and the arc word layout for the max-flow level-graph block.
package mflg_pkg;

  localparam int MAX_NODES  = 256;
  localparam int NODE_W     = 8;
  localparam int NCOUNT_W   = 9;
  localparam int MAX_EDGES  = 4096;
  localparam int EDGE_CNT_W = 13;
  localparam int ARC_DEPTH  = 2 * MAX_EDGES;
  localparam int ARC_W      = 13;
  localparam int ARC_PTR_W  = 14;
  localparam int CAP_W      = 32;
  localparam int FLOW_W     = 46;
  localparam int LEVEL_W    = 8;
  localparam int CNT_W      = 9;
  localparam int CFG_W      = 9;
  localparam int CFG_IDX_W  = 2;

  localparam logic [ARC_PTR_W-1:0] ARC_NONE = ARC_PTR_W'(ARC_DEPTH);

  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SINK       = 2'd2;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
  localparam logic [1:0] STATUS_BAD_NODE = 2'd2;

  typedef struct packed {
    logic [NODE_W-1:0]    target;
    logic [CAP_W-1:0]     residual;
    logic [ARC_PTR_W-1:0] next;
  } arc_word_t;

endpackage

@@ rtl/mflg_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module mflg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/max_flow_level_graph.sv @@
// Top level: edge loader and Dinic max-flow sequencer over arc and node memories.
//
// Edges arrive one beat at a time and each is linked into the arc memory in states
// S_E1 to S_E3 as a forward and a reverse arc; in_stall is high while that runs. A beat with
// last_edge set then starts the flow run: a breadth-first pass that assigns levels,
// then depth-first augmenting searches with current-arc pointers and a path stack,
// repeated until the sink is unreachable. Every arc visit goes through the single read
// port of the arc memory, and each augmentation reads and writes every arc of its path;
// the length of the run depends on the graph.
// The result beat is held in an output register until taken; the graph is then
// empty again. No clearing pass is needed after reset.
module max_flow_level_graph
  import mflg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [NODE_W-1:0]     in_from_node,
  input  logic [NODE_W-1:0]     in_to_node,
  input  logic [CAP_W-1:0]      in_capacity,
  input  logic                  in_last_edge,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [FLOW_W-1:0]     out_flow_value,
  output logic [1:0]            out_status
);

  typedef enum logic [4:0] {
    S_IDLE, S_E1, S_E2, S_E3, S_START,
    S_BFS_INIT, S_BFS_POP, S_BFS_U, S_BFS_U2, S_BFS_ARC, S_BFS_ARC2, S_BFS_END,
    S_BF_INIT, S_DF_CHK, S_DF_CUR, S_DF_A, S_DF_ARC, S_DF_LV,
    S_DEAD, S_DEAD2, S_DEAD3, S_DEAD4,
    S_AM, S_AM2, S_AM3, S_AU, S_AU2, S_AU3, S_AU4,
    S_DONE, S_OUT
  } state_t;

  state_t                state_r, state_nxt;
  logic [NCOUNT_W-1:0]   node_count_r;
  logic [NODE_W-1:0]     src_r, snk_r;
  logic [EDGE_CNT_W-1:0] edge_cnt_r, edge_cnt_nxt;
  logic [1:0]            err_r, err_nxt;
  logic [NODE_W-1:0]     from_r, from_nxt, to_r, to_nxt;
  logic [CAP_W-1:0]      cap_r, cap_nxt;
  logic                  last_r, last_nxt;
  logic [MAX_NODES-1:0]  fv_r, fv_nxt, lv_r, lv_nxt, cv_r, cv_nxt;
  logic [CNT_W-1:0]      head_r, head_nxt, tail_r, tail_nxt;
  logic [CNT_W-1:0]      depth_r, depth_nxt, idx_r, idx_nxt;
  logic [NODE_W-1:0]     u_r, u_nxt;
  logic [LEVEL_W-1:0]    lu_r, lu_nxt;
  logic [ARC_PTR_W-1:0]  a_r, a_nxt;
  arc_word_t             arc_r, arc_nxt;
  logic [CAP_W-1:0]      b_r, b_nxt;
  logic [FLOW_W-1:0]     total_r, total_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [FLOW_W-1:0]     out_flow_r, out_flow_nxt;
  logic [1:0]            out_status_r, out_status_nxt;

  logic [NCOUNT_W-1:0]   nc;
  logic [ARC_W-1:0]      arc_base;

  // memory ports
  logic                  arc_we;
  logic [ARC_W-1:0]      arc_waddr, arc_raddr;
  arc_word_t             arc_wdata, arc_rdata;
  logic                  fa_we;
  logic [NODE_W-1:0]     fa_waddr, fa_raddr;
  logic [ARC_W-1:0]      fa_wdata, fa_rdata;
  logic                  lvl_we;
  logic [NODE_W-1:0]     lvl_waddr, lvl_raddr;
  logic [LEVEL_W-1:0]    lvl_wdata, lvl_rdata;
  logic                  cur_we;
  logic [NODE_W-1:0]     cur_waddr, cur_raddr;
  logic [ARC_PTR_W-1:0]  cur_wdata, cur_rdata;
  logic                  q_we;
  logic [NODE_W-1:0]     q_waddr, q_raddr, q_wdata, q_rdata;
  logic                  stk_we;
  logic [NODE_W-1:0]     stk_waddr, stk_raddr;
  logic [ARC_W-1:0]      stk_wdata, stk_rdata;

  mflg_ram #(.WIDTH($bits(arc_word_t)), .DEPTH(ARC_DEPTH)) u_arc_ram (
    .clk(clk), .we(arc_we), .waddr(arc_waddr), .wdata(arc_wdata),
    .raddr(arc_raddr), .rdata(arc_rdata));
  mflg_ram #(.WIDTH(ARC_W), .DEPTH(MAX_NODES)) u_first_ram (
    .clk(clk), .we(fa_we), .waddr(fa_waddr), .wdata(fa_wdata),
    .raddr(fa_raddr), .rdata(fa_rdata));
  mflg_ram #(.WIDTH(LEVEL_W), .DEPTH(MAX_NODES)) u_level_ram (
    .clk(clk), .we(lvl_we), .waddr(lvl_waddr), .wdata(lvl_wdata),
    .raddr(lvl_raddr), .rdata(lvl_rdata));
  mflg_ram #(.WIDTH(ARC_PTR_W), .DEPTH(MAX_NODES)) u_cur_ram (
    .clk(clk), .we(cur_we), .waddr(cur_waddr), .wdata(cur_wdata),
    .raddr(cur_raddr), .rdata(cur_rdata));
  mflg_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_queue_ram (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata));
  mflg_ram #(.WIDTH(ARC_W), .DEPTH(MAX_NODES)) u_stack_ram (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata));

  assign nc       = (node_count_r > NCOUNT_W'(MAX_NODES)) ? NCOUNT_W'(MAX_NODES)
                                                          : node_count_r;
  assign arc_base = {edge_cnt_r[ARC_W-2:0], 1'b0};

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_flow_value = out_flow_r;
  assign out_status     = out_status_r;

  always_comb begin
    state_nxt      = state_r;
    edge_cnt_nxt   = edge_cnt_r;
    err_nxt        = err_r;
    from_nxt       = from_r;
    to_nxt         = to_r;
    cap_nxt        = cap_r;
    last_nxt       = last_r;
    fv_nxt         = fv_r;
    lv_nxt         = lv_r;
    cv_nxt         = cv_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    depth_nxt      = depth_r;
    idx_nxt        = idx_r;
    u_nxt          = u_r;
    lu_nxt         = lu_r;
    a_nxt          = a_r;
    arc_nxt        = arc_r;
    b_nxt          = b_r;
    total_nxt      = total_r;
    out_valid_nxt  = out_valid_r;
    out_flow_nxt   = out_flow_r;
    out_status_nxt = out_status_r;

    arc_we    = 1'b0;
    arc_waddr = '0;
    arc_wdata = arc_rdata;
    arc_raddr = '0;
    fa_we     = 1'b0;
    fa_waddr  = from_r;
    fa_wdata  = arc_base;
    fa_raddr  = in_from_node;
    lvl_we    = 1'b0;
    lvl_waddr = src_r;
    lvl_wdata = '0;
    lvl_raddr = u_r;
    cur_we    = 1'b0;
    cur_waddr = u_r;
    cur_wdata = arc_r.next;
    cur_raddr = u_r;
    q_we      = 1'b0;
    q_waddr   = '0;
    q_wdata   = src_r;
    q_raddr   = head_r[NODE_W-1:0];
    stk_we    = 1'b0;
    stk_waddr = depth_r[NODE_W-1:0];
    stk_wdata = a_r[ARC_W-1:0];
    stk_raddr = idx_r[NODE_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          from_nxt = in_from_node;
          to_nxt   = in_to_node;
          cap_nxt  = in_capacity;
          last_nxt = in_last_edge;
          if ({1'b0, in_from_node} >= nc || {1'b0, in_to_node} >= nc) begin
            err_nxt   = err_r | 2'b10;
            state_nxt = in_last_edge ? S_START : S_IDLE;
          end else if (edge_cnt_r >= EDGE_CNT_W'(MAX_EDGES)) begin
            err_nxt   = err_r | 2'b01;
            state_nxt = in_last_edge ? S_START : S_IDLE;
          end else begin
            state_nxt = S_E1;
          end
        end
      end
      S_E1: begin
        // link forward arc at the head of the tail node's list
        arc_we           = 1'b1;
        arc_waddr        = arc_base;
        arc_wdata.target = to_r;
        arc_wdata.residual = cap_r;
        arc_wdata.next   = fv_r[from_r] ? {1'b0, fa_rdata} : ARC_NONE;
        fa_we            = 1'b1;
        fa_waddr         = from_r;
        fa_wdata         = arc_base;
        fv_nxt[from_r]   = 1'b1;
        state_nxt        = S_E2;
      end
      S_E2: begin
        fa_raddr  = to_r;
        state_nxt = S_E3;
      end
      S_E3: begin
        arc_we           = 1'b1;
        arc_waddr        = arc_base | ARC_W'(1);
        arc_wdata.target = from_r;
        arc_wdata.residual = '0;
        arc_wdata.next   = fv_r[to_r] ? {1'b0, fa_rdata} : ARC_NONE;
        fa_we            = 1'b1;
        fa_waddr         = to_r;
        fa_wdata         = arc_base | ARC_W'(1);
        fv_nxt[to_r]     = 1'b1;
        edge_cnt_nxt     = edge_cnt_r + EDGE_CNT_W'(1);
        state_nxt        = last_r ? S_START : S_IDLE;
      end
      S_START: begin
        total_nxt = '0;
        if ({1'b0, src_r} < nc && {1'b0, snk_r} < nc && src_r != snk_r) begin
          state_nxt = S_BFS_INIT;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_BFS_INIT: begin
        lv_nxt        = '0;
        lv_nxt[src_r] = 1'b1;
        lvl_we        = 1'b1;
        lvl_waddr     = src_r;
        lvl_wdata     = '0;
        q_we          = 1'b1;
        q_waddr       = '0;
        q_wdata       = src_r;
        head_nxt      = '0;
        tail_nxt      = CNT_W'(1);
        state_nxt     = S_BFS_POP;
      end
      S_BFS_POP: begin
        if (head_r < tail_r) begin
          q_raddr   = head_r[NODE_W-1:0];
          head_nxt  = head_r + CNT_W'(1);
          state_nxt = S_BFS_U;
        end else begin
          state_nxt = S_BFS_END;
        end
      end
      S_BFS_U: begin
        u_nxt     = q_rdata;
        fa_raddr  = q_rdata;
        lvl_raddr = q_rdata;
        state_nxt = S_BFS_U2;
      end
      S_BFS_U2: begin
        lu_nxt    = lvl_rdata;
        a_nxt     = fv_r[u_r] ? {1'b0, fa_rdata} : ARC_NONE;
        state_nxt = S_BFS_ARC;
      end
      S_BFS_ARC: begin
        if (a_r[ARC_PTR_W-1]) begin
          state_nxt = S_BFS_POP;
        end else begin
          arc_raddr = a_r[ARC_W-1:0];
          state_nxt = S_BFS_ARC2;
        end
      end
      S_BFS_ARC2: begin
        if ({1'b0, arc_rdata.target} < nc && !lv_r[arc_rdata.target]
            && arc_rdata.residual != '0 && !tail_r[CNT_W-1]) begin
          lv_nxt[arc_rdata.target] = 1'b1;
          lvl_we    = 1'b1;
          lvl_waddr = arc_rdata.target;
          lvl_wdata = lu_r + LEVEL_W'(1);
          q_we      = 1'b1;
          q_waddr   = tail_r[NODE_W-1:0];
          q_wdata   = arc_rdata.target;
          tail_nxt  = tail_r + CNT_W'(1);
        end
        a_nxt     = arc_rdata.next;
        state_nxt = S_BFS_ARC;
      end
      S_BFS_END: begin
        state_nxt = lv_r[snk_r] ? S_BF_INIT : S_DONE;
      end
      S_BF_INIT: begin
        cv_nxt    = '0;
        depth_nxt = '0;
        u_nxt     = src_r;
        state_nxt = S_DF_CHK;
      end
      S_DF_CHK: begin
        if (u_r == snk_r) begin
          idx_nxt   = '0;
          b_nxt     = '1;
          state_nxt = S_AM;
        end else begin
          cur_raddr = u_r;
          fa_raddr  = u_r;
          lvl_raddr = u_r;
          state_nxt = S_DF_CUR;
        end
      end
      S_DF_CUR: begin
        lu_nxt = lvl_rdata;
        if (cv_r[u_r]) begin
          a_nxt = cur_rdata;
        end else begin
          a_nxt = fv_r[u_r] ? {1'b0, fa_rdata} : ARC_NONE;
        end
        state_nxt = S_DF_A;
      end
      S_DF_A: begin
        if (a_r[ARC_PTR_W-1]) begin
          state_nxt = S_DEAD;
        end else begin
          arc_raddr = a_r[ARC_W-1:0];
          state_nxt = S_DF_ARC;
        end
      end
      S_DF_ARC: begin
        arc_nxt   = arc_rdata;
        lvl_raddr = arc_rdata.target;
        state_nxt = S_DF_LV;
      end
      S_DF_LV: begin
        if ({1'b0, arc_r.target} < nc && lv_r[arc_r.target]
            && {1'b0, lvl_rdata} == {1'b0, lu_r} + CNT_W'(1)
            && arc_r.residual != '0 && !depth_r[CNT_W-1]) begin
          // advance along the arc
          stk_we    = 1'b1;
          stk_waddr = depth_r[NODE_W-1:0];
          stk_wdata = a_r[ARC_W-1:0];
          depth_nxt = depth_r + CNT_W'(1);
          u_nxt     = arc_r.target;
          state_nxt = S_DF_CHK;
        end else begin
          cur_we     = 1'b1;
          cur_waddr  = u_r;
          cur_wdata  = arc_r.next;
          cv_nxt[u_r] = 1'b1;
          a_nxt      = arc_r.next;
          state_nxt  = S_DF_A;
        end
      end
      S_DEAD: begin
        // drop the node from the level graph and retreat one arc
        lv_nxt[u_r] = 1'b0;
        if (depth_r == '0) begin
          state_nxt = S_BFS_INIT;
        end else begin
          depth_nxt = depth_r - CNT_W'(1);
          stk_raddr = NODE_W'(depth_r - CNT_W'(1));
          state_nxt = S_DEAD2;
        end
      end
      S_DEAD2: begin
        a_nxt     = {1'b0, stk_rdata};
        arc_raddr = stk_rdata ^ ARC_W'(1);
        state_nxt = S_DEAD3;
      end
      S_DEAD3: begin
        u_nxt     = arc_rdata.target;
        arc_raddr = a_r[ARC_W-1:0];
        state_nxt = S_DEAD4;
      end
      S_DEAD4: begin
        cur_we      = 1'b1;
        cur_waddr   = u_r;
        cur_wdata   = arc_rdata.next;
        cv_nxt[u_r] = 1'b1;
        state_nxt   = S_DF_CHK;
      end
      S_AM: begin
        if (idx_r < depth_r) begin
          stk_raddr = idx_r[NODE_W-1:0];
          state_nxt = S_AM2;
        end else begin
          idx_nxt   = '0;
          state_nxt = S_AU;
        end
      end
      S_AM2: begin
        arc_raddr = stk_rdata;
        state_nxt = S_AM3;
      end
      S_AM3: begin
        if (arc_rdata.residual < b_r) begin
          b_nxt = arc_rdata.residual;
        end
        idx_nxt   = idx_r + CNT_W'(1);
        state_nxt = S_AM;
      end
      S_AU: begin
        if (idx_r < depth_r) begin
          stk_raddr = idx_r[NODE_W-1:0];
          state_nxt = S_AU2;
        end else begin
          total_nxt = total_r + FLOW_W'(b_r);
          depth_nxt = '0;
          u_nxt     = src_r;
          state_nxt = S_DF_CHK;
        end
      end
      S_AU2: begin
        a_nxt     = {1'b0, stk_rdata};
        arc_raddr = stk_rdata;
        state_nxt = S_AU3;
      end
      S_AU3: begin
        arc_we             = 1'b1;
        arc_waddr          = a_r[ARC_W-1:0];
        arc_wdata          = arc_rdata;
        arc_wdata.residual = arc_rdata.residual - b_r;
        arc_raddr          = a_r[ARC_W-1:0] ^ ARC_W'(1);
        state_nxt          = S_AU4;
      end
      S_AU4: begin
        arc_we             = 1'b1;
        arc_waddr          = a_r[ARC_W-1:0] ^ ARC_W'(1);
        arc_wdata          = arc_rdata;
        arc_wdata.residual = arc_rdata.residual + b_r;
        idx_nxt            = idx_r + CNT_W'(1);
        state_nxt          = S_AU;
      end
      S_DONE: begin
        out_valid_nxt = 1'b1;
        out_flow_nxt  = total_r;
        if (err_r[0]) begin
          out_status_nxt = STATUS_OVERFLOW;
        end else if (err_r[1]) begin
          out_status_nxt = STATUS_BAD_NODE;
        end else begin
          out_status_nxt = STATUS_OK;
        end
        fv_nxt       = '0;
        edge_cnt_nxt = '0;
        err_nxt      = '0;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        // hold the result beat until taken
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      node_count_r <= NCOUNT_W'(MAX_NODES);
      src_r        <= '0;
      snk_r        <= NODE_W'(1);
      edge_cnt_r   <= '0;
      err_r        <= '0;
      fv_r         <= '0;
      lv_r         <= '0;
      cv_r         <= '0;
      depth_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      edge_cnt_r  <= edge_cnt_nxt;
      err_r       <= err_nxt;
      fv_r        <= fv_nxt;
      lv_r        <= lv_nxt;
      cv_r        <= cv_nxt;
      depth_r     <= depth_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_NODE_COUNT: node_count_r <= cfg_data;
          REG_SOURCE:     src_r        <= cfg_data[NODE_W-1:0];
          REG_SINK:       snk_r        <= cfg_data[NODE_W-1:0];
          default:        ;
        endcase
      end
    end
    from_r       <= from_nxt;
    to_r         <= to_nxt;
    cap_r        <= cap_nxt;
    last_r       <= last_nxt;
    head_r       <= head_nxt;
    tail_r       <= tail_nxt;
    idx_r        <= idx_nxt;
    u_r          <= u_nxt;
    lu_r         <= lu_nxt;
    a_r          <= a_nxt;
    arc_r        <= arc_nxt;
    b_r          <= b_nxt;
    total_r      <= total_nxt;
    out_flow_r   <= out_flow_nxt;
    out_status_r <= out_status_nxt;
  end

  a_edge_bound: assert property (@(posedge clk) disable iff (!rst_n)
    edge_cnt_r <= EDGE_CNT_W'(MAX_EDGES))
    else $error("edge count beyond store size");

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= CNT_W'(MAX_NODES))
    else $error("path stack beyond node count");

  a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> in_stall)
    else $error("input open while result beat pending");

  a_graph_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (edge_cnt_r == '0 && err_r == '0 && fv_r == '0))
    else $error("graph not cleared with result beat");

endmodule

@@ dv/flow_checker.sv @@
// Checker for max_flow_level_graph: tracks the edge store, predicts each flow result, compares.
module flow_checker
  import mflg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [NODE_W-1:0]    in_from_node,
  input  logic [NODE_W-1:0]    in_to_node,
  input  logic [CAP_W-1:0]     in_capacity,
  input  logic                 in_last_edge,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [FLOW_W-1:0]    out_flow_value,
  input  logic [1:0]           out_status,
  output int                   fail_count,
  output int                   pending,
  output int                   results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NO_ARC = ARC_DEPTH;

  typedef struct {
    logic [FLOW_W-1:0] flow_value;
    logic [1:0]        status;
  } flow_result_t;

  flow_result_t expected_flows[$];

  // shadow of the block's configuration
  int unsigned node_count_q, source_q, sink_q;

  // shadow graph in arc-list form
  logic [NODE_W-1:0] arc_head [ARC_DEPTH];
  longint unsigned   arc_cap  [ARC_DEPTH];
  int                arc_link [ARC_DEPTH];
  int                first_arc [MAX_NODES];
  int                node_lvl  [MAX_NODES];
  int                cur_arc   [MAX_NODES];
  int                bfs_queue [MAX_NODES];
  int                path_arcs [MAX_NODES];
  int                stored_edges;
  logic [1:0]        drop_flags;

  function automatic void clear_graph();
    for (int i = 0; i < MAX_NODES; i++) begin
      first_arc[i] = NO_ARC;
      node_lvl[i] = -1;
    end
    stored_edges = 0;
    drop_flags = '0;
  endfunction

  function automatic int active_nodes();
    return (node_count_q > MAX_NODES) ? MAX_NODES : int'(node_count_q);
  endfunction

  function automatic void store_arc_pair(int f, int t, longint unsigned cap);
    int nc;
    int a;
    nc = active_nodes();
    if (f >= nc || t >= nc) begin
      drop_flags[1] = 1'b1;
      return;
    end
    if (stored_edges >= MAX_EDGES) begin
      drop_flags[0] = 1'b1;
      return;
    end
    a = 2 * stored_edges;
    arc_head[a] = t;
    arc_cap[a] = cap;
    arc_link[a] = first_arc[f];
    first_arc[f] = a;
    arc_head[a + 1] = f;
    arc_cap[a + 1] = 0;
    arc_link[a + 1] = first_arc[t];
    first_arc[t] = a + 1;
    stored_edges++;
  endfunction

  function automatic bit assign_levels(int s, int t, int nc);
    int head, tail, u, v, a;
    for (int i = 0; i < MAX_NODES; i++) node_lvl[i] = -1;
    node_lvl[s] = 0;
    bfs_queue[0] = s;
    head = 0;
    tail = 1;
    while (head < tail) begin
      u = bfs_queue[head];
      head++;
      a = first_arc[u];
      while (a != NO_ARC) begin
        v = arc_head[a];
        if (v < nc && node_lvl[v] < 0 && arc_cap[a] > 0 && tail < MAX_NODES) begin
          node_lvl[v] = node_lvl[u] + 1;
          bfs_queue[tail] = v;
          tail++;
        end
        a = arc_link[a];
      end
    end
    return node_lvl[t] >= 0;
  endfunction

  function automatic longint unsigned push_blocking(int s, int t, int nc);
    int depth, u, v, a;
    longint unsigned total, neck;
    depth = 0;
    u = s;
    total = 0;
    for (int i = 0; i < MAX_NODES; i++) cur_arc[i] = first_arc[i];
    while (1) begin
      if (u == t) begin
        neck = '1;
        for (int i = 0; i < depth; i++)
          if (arc_cap[path_arcs[i]] < neck) neck = arc_cap[path_arcs[i]];
        for (int i = 0; i < depth; i++) begin
          arc_cap[path_arcs[i]] -= neck;
          arc_cap[path_arcs[i] ^ 1] += neck;
        end
        total += neck;
        depth = 0;
        u = s;
        continue;
      end
      a = cur_arc[u];
      if (a != NO_ARC) begin
        v = arc_head[a];
        if (v < nc && node_lvl[v] >= 0 && node_lvl[v] == node_lvl[u] + 1 &&
            arc_cap[a] > 0 && depth < MAX_NODES) begin
          path_arcs[depth] = a;
          depth++;
          u = v;
        end else begin
          cur_arc[u] = arc_link[a];
        end
        continue;
      end
      // dead end: retire the node and retreat one arc
      node_lvl[u] = -1;
      if (depth == 0) break;
      depth--;
      a = path_arcs[depth];
      u = arc_head[a ^ 1];
      cur_arc[u] = arc_link[a];
    end
    return total;
  endfunction

  function automatic flow_result_t solve_flow();
    flow_result_t r;
    longint unsigned flow;
    int nc, s, t;
    nc = active_nodes();
    s = source_q;
    t = sink_q;
    flow = 0;
    if (s < nc && t < nc && s != t)
      while (assign_levels(s, t, nc)) flow += push_blocking(s, t, nc);
    r.flow_value = flow[FLOW_W-1:0];
    r.status = drop_flags[0] ? STATUS_OVERFLOW :
               (drop_flags[1] ? STATUS_BAD_NODE : STATUS_OK);
    clear_graph();
    return r;
  endfunction

  always @(posedge clk) begin
    flow_result_t got, want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      node_count_q <= 256;
      source_q <= 0;
      sink_q <= 1;
      clear_graph();
      expected_flows.delete();
      fail_count <= 0;
      results_seen <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_NODE_COUNT: node_count_q <= cfg_data;
          REG_SOURCE:     source_q <= cfg_data[NODE_W-1:0];
          REG_SINK:       sink_q <= cfg_data[NODE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        store_arc_pair(in_from_node, in_to_node, in_capacity);
        if (in_last_edge) expected_flows.insert(expected_flows.size(), solve_flow());
      end
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        got.flow_value = out_flow_value;
        got.status = out_status;
        if (expected_flows.size() == 0) begin
          $error("result beat with nothing expected: flow_value %0d status %0d",
                 got.flow_value, got.status);
          errs++;
        end else begin
          want = expected_flows.pop_front();
          if (got.flow_value !== want.flow_value) begin
            $error("flow_value: expected %0d, got %0d", want.flow_value, got.flow_value);
            errs++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end

  assign pending = expected_flows.size();

endmodule

@@ dv/tb_top.sv @@
// Testbench top for max_flow_level_graph: clock, reset, edge and config stimulus, verdict.
module tb_top;
  import mflg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 4000000;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [NODE_W-1:0]    in_from_node;
  logic [NODE_W-1:0]    in_to_node;
  logic [CAP_W-1:0]     in_capacity;
  logic                 in_last_edge;
  logic                 out_valid;
  logic                 out_stall;
  logic [FLOW_W-1:0]    out_flow_value;
  logic [1:0]           out_status;

  int fail_count, pending, results_seen;
  int beats_sent, burst_left, graphs_run;
  int idle_cycles = 0;
  int nc_cur, src_cur, snk_cur;

  max_flow_level_graph dut (.*);

  flow_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result side stalls in modes: free-running, light, heavy
  int stall_mode = 0;
  int stall_left = 0;
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(8, 80);
    end
    stall_left--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // watchdog: cycles with no beat on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // call at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_edge(input int f, input int t, input logic [CAP_W-1:0] cap,
                           input bit last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 5) == 0) ? $urandom_range(4, 20) : $urandom_range(0, 3);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    in_from_node <= f[NODE_W-1:0];
    in_to_node <= t[NODE_W-1:0];
    in_capacity <= cap;
    in_last_edge <= last;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    burst_left--;
    beats_sent++;
  endtask

  // drop valid and wait out the pending result plus any tail of work
  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic set_cfg(input int nc, input int s, input int t);
    cfg_we <= 1'b1;
    cfg_index <= REG_NODE_COUNT;
    cfg_data <= nc[CFG_W-1:0];
    @(negedge clk);
    cfg_index <= REG_SOURCE;
    cfg_data <= s[CFG_W-1:0];
    @(negedge clk);
    cfg_index <= REG_SINK;
    cfg_data <= t[CFG_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    nc_cur = (nc > MAX_NODES) ? MAX_NODES : nc;
    src_cur = s;
    snk_cur = t;
  endtask

  function automatic logic [CAP_W-1:0] pick_cap();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return $urandom;
      default: return $urandom_range(1, 100);
    endcase
  endfunction

  function automatic int pick_node(input bit toward_sink);
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return $urandom_range(0, 255);
    if (r < 6 && src_cur < nc_cur && !toward_sink) return src_cur;
    if (r < 6 && snk_cur < nc_cur && toward_sink) return snk_cur;
    return $urandom_range(0, nc_cur - 1);
  endfunction

  task automatic run_graph(input int edges);
    for (int i = 0; i < edges; i++)
      send_edge(pick_node(1'b0), pick_node(1'b1), pick_cap(), i == edges - 1);
    graphs_run++;
  endtask

  initial begin
    int nc, s, t;
    cfg_we = 1'b0;
    cfg_index = REG_NODE_COUNT;
    cfg_data = '0;
    in_valid = 1'b0;
    in_from_node = '0;
    in_to_node = '0;
    in_capacity = '0;
    in_last_edge = 1'b0;
    burst_left = 0;
    beats_sent = 0;
    graphs_run = 0;
    nc_cur = MAX_NODES;
    src_cur = 0;
    snk_cur = 1;
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset settings: a full-width path through node 255 and a direct edge into the sink
    send_edge(255, 1, '1, 1'b0);
    send_edge(0, 255, '1, 1'b0);
    send_edge(0, 1, 32'h8000_0001, 1'b1);
    settle();

    // diamond with zero capacity, self loop and a parallel path
    set_cfg(4, 0, 3);
    send_edge(0, 1, '1, 1'b0);
    send_edge(1, 3, '1, 1'b0);
    send_edge(0, 2, '0, 1'b0);
    send_edge(2, 2, 5, 1'b0);
    send_edge(1, 2, 9, 1'b0);
    send_edge(2, 3, 7, 1'b1);
    settle();

    // invalid node is dropped and flagged
    send_edge(0, 3, 11, 1'b0);
    send_edge(9, 1, 4, 1'b1);
    settle();

    // source equal to sink; then sink out of range
    set_cfg(2, 1, 1);
    send_edge(1, 0, 3, 1'b0);
    send_edge(0, 1, 3, 1'b1);
    settle();
    set_cfg(2, 0, 200);
    send_edge(0, 1, 3, 1'b1);
    settle();

    // oversized node count acts as the full count
    set_cfg(511, 255, 0);
    send_edge(255, 128, 32'hAAAA_AAAA, 1'b0);
    send_edge(128, 0, 32'h5555_5555, 1'b0);
    send_edge(255, 0, '1, 1'b1);
    settle();

    // node count lowered after loading hides a route
    set_cfg(8, 0, 1);
    send_edge(0, 7, 50, 1'b0);
    send_edge(7, 1, 50, 1'b0);
    send_edge(0, 1, 20, 1'b0);
    settle();
    set_cfg(4, 0, 1);
    send_edge(0, 1, 1, 1'b1);
    settle();

    graphs_run = 0;
    while (beats_sent < 900) begin
      if ($urandom_range(0, 3) == 0 || graphs_run == 0) begin
        settle();
        case ($urandom_range(0, 7))
          0: nc = 2;
          1: nc = 256;
          2: nc = 511;
          3: nc = $urandom_range(257, 510);
          default: nc = $urandom_range(3, 20);
        endcase
        s = $urandom_range(0, ((nc > 256) ? 256 : nc) - 1);
        t = $urandom_range(0, ((nc > 256) ? 256 : nc) - 1);
        case ($urandom_range(0, 9))
          0: t = s;
          1: s = $urandom_range(0, 255);
          2: t = $urandom_range(0, 255);
          default: ;
        endcase
        set_cfg(nc, s, t);
      end
      run_graph(($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 25));
    end
    settle();

    repeat (200) @(negedge clk);
    $display("Edge loads with bad nodes and config corners, then %0d random graphs",
             graphs_run);
    $display("(%0d edge beats in all); %0d flow results checked.", beats_sent, results_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/mflg_pkg.sv
rtl/mflg_ram.sv
rtl/max_flow_level_graph.sv
dv/flow_checker.sv
dv/tb_top.sv
